[src/cpi_pkg.sv]
`default_nettype none
package cpi_pkg;
	localparam int unsigned NumAxes    = 3;
	localparam int unsigned SqrtSteps  = 32;
	localparam int unsigned DivSteps   = 16;
	localparam int unsigned BackStages = 6;
	localparam int unsigned QueueDepth = 2;
	// Edges from the accepting edge to the edge that samples done high.
	localparam int unsigned CpiLatency = SqrtSteps + DivSteps + BackStages + 3;

	localparam logic [30:0] ResetOneQ16 = 31'd65536;
	localparam logic [31:0] ResetUpper  = 32'h03E8_0000;
	localparam logic [31:0] ResetLower  = 32'hFC18_0000;

	typedef enum logic [2:0] {
		REG_SPEED_REFERENCE = 3'd0,
		REG_TIME_STEP       = 3'd1,
		REG_X_UPPER         = 3'd2,
		REG_X_LOWER         = 3'd3,
		REG_Y_UPPER         = 3'd4,
		REG_Y_LOWER         = 3'd5,
		REG_Z_UPPER         = 3'd6,
		REG_Z_LOWER         = 3'd7
	} cpi_reg_t;

	typedef struct packed {
		logic [NumAxes-1:0][31:0] pos;
		logic [NumAxes-1:0][31:0] frc;
		logic [NumAxes-1:0][15:0] orient;
		logic [NumAxes-1:0][15:0] dir;
		logic [15:0]              dir_factor;
		logic [15:0]              prop_factor;
	} cpi_item_t;

	typedef struct packed {
		cpi_item_t                item;
		logic [NumAxes-1:0][16:0] unit;
	} cpi_work_t;

	typedef struct packed {
		logic [30:0]              speed_ref;
		logic [30:0]              time_step;
		logic [NumAxes-1:0][31:0] upper;
		logic [NumAxes-1:0][31:0] lower;
	} cpi_cfg_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end else if (v < 64'shFFFF_FFFF_8000_0000) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction
endpackage
`default_nettype wire

[src/cpi_front.sv]
`default_nettype none
module cpi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  cpi_pkg::cpi_item_t in_item,
	output logic               out_valid,
	output cpi_pkg::cpi_work_t out_work
);
	import cpi_pkg::*;

	// Squared length of the random direction, taken at the accepting edge.
	logic [31:0] sq [NumAxes];
	logic [31:0] sum_d;

	always_comb begin
		for (int a = 0; a < NumAxes; a++) begin
			sq[a] = 32'($signed(in_item.dir[a]) * $signed(in_item.dir[a]));
		end
		sum_d = sq[0] + sq[1] + sq[2];
	end

	// Square root pipeline: one result bit per stage.
	logic [63:0]      rt_n_s [SqrtSteps+1];
	logic [63:0]      rt_r_s [SqrtSteps+1];
	cpi_item_t        rt_item_s [SqrtSteps+1];
	logic [SqrtSteps:0] rt_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else begin
			rt_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rt_n_s[0]    <= {2'b0, sum_d, 30'b0};
		rt_r_s[0]    <= 64'd0;
		rt_item_s[0] <= in_item;
	end

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		localparam logic [63:0] Bit = 64'd1 << (2 * (SqrtSteps - 1 - k));
		logic [63:0] trial;
		logic        ge;
		always_comb begin
			trial = rt_r_s[k] + Bit;
			ge    = rt_n_s[k] >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			rt_n_s[k+1]    <= ge ? rt_n_s[k] - trial : rt_n_s[k];
			rt_r_s[k+1]    <= ge ? (rt_r_s[k] >> 1) + Bit : rt_r_s[k] >> 1;
			rt_item_s[k+1] <= rt_item_s[k];
		end
	end

	// Restoring divide of each magnitude by the length, one quotient bit per stage.
	logic [NumAxes-1:0][46:0] dv_rem_s [DivSteps+1];
	logic [NumAxes-1:0][15:0] dv_q_s   [DivSteps+1];
	logic [30:0]              dv_len_s [DivSteps+1];
	cpi_item_t                dv_item_s [DivSteps+1];
	logic [DivSteps:0]        dv_v_s;
	logic [NumAxes-1:0][16:0] mag;

	always_comb begin
		for (int a = 0; a < NumAxes; a++) begin
			mag[a] = rt_item_s[SqrtSteps].dir[a][15]
				? 17'd0 - {rt_item_s[SqrtSteps].dir[a][15], rt_item_s[SqrtSteps].dir[a]}
				: {1'b0, rt_item_s[SqrtSteps].dir[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[SqrtSteps];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NumAxes; a++) begin
			dv_rem_s[0][a] <= {mag[a], 30'b0};
		end
		dv_q_s[0]    <= '0;
		dv_len_s[0]  <= rt_r_s[SqrtSteps][30:0];
		dv_item_s[0] <= rt_item_s[SqrtSteps];
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		localparam int Sh = DivSteps - 1 - j;
		logic [46:0] trial;
		assign trial = {16'b0, dv_len_s[j]} << Sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			for (int a = 0; a < NumAxes; a++) begin
				if (dv_rem_s[j][a] >= trial) begin
					dv_rem_s[j+1][a]   <= dv_rem_s[j][a] - trial;
					dv_q_s[j+1][a]     <= dv_q_s[j][a] | (16'd1 << Sh);
				end else begin
					dv_rem_s[j+1][a]   <= dv_rem_s[j][a];
					dv_q_s[j+1][a]     <= dv_q_s[j][a];
				end
			end
			dv_len_s[j+1]  <= dv_len_s[j];
			dv_item_s[j+1] <= dv_item_s[j];
		end
	end

	// A zero length means a zero direction.
	always_comb begin
		out_valid     = dv_v_s[DivSteps];
		out_work.item = dv_item_s[DivSteps];
		for (int a = 0; a < NumAxes; a++) begin
			if (dv_len_s[DivSteps] == 31'd0) begin
				out_work.unit[a] = 17'd0;
			end else if (dv_item_s[DivSteps].dir[a][15]) begin
				out_work.unit[a] = 17'd0 - {1'b0, dv_q_s[DivSteps][a]};
			end else begin
				out_work.unit[a] = {1'b0, dv_q_s[DivSteps][a]};
			end
		end
	end
endmodule
`default_nettype wire

[src/cpi_queue.sv]
`default_nettype none
module cpi_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cpi_pkg::cpi_work_t push_data,
	input  logic               pop,
	output logic               not_empty,
	output logic               full,
	output cpi_pkg::cpi_work_t pop_data
);
	import cpi_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	cpi_work_t           mem_q [QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign not_empty = count_q != CntW'(0);
	assign full      = count_q == CntW'(QueueDepth);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

[src/cpi_back.sv]
`default_nettype none
module cpi_back #(
	parameter bit PERIODIC_WRAP = 1'b0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  cpi_pkg::cpi_work_t                     in_work,
	input  cpi_pkg::cpi_cfg_t                      cfg,
	output logic                                   out_valid,
	output logic [cpi_pkg::NumAxes-1:0][31:0]      new_pos,
	output logic [cpi_pkg::NumAxes-1:0][31:0]      vel
);
	import cpi_pkg::*;

	logic [BackStages:1] v_s;
	logic [46:0]         kd_s1;
	logic [46:0]         kp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[BackStages-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		kd_s1 <= {16'b0, cfg.speed_ref} * {31'b0, in_work.item.dir_factor};
		kp_s1 <= {16'b0, cfg.speed_ref} * {31'b0, in_work.item.prop_factor};
	end

	assign out_valid = v_s[BackStages];

	for (genvar a = 0; a < NumAxes; a++) begin : g_axis
		logic signed [63:0] fdt_s1;
		logic [31:0]        pos_s1, pos_s2, pos_s3, pos_s4;
		logic [15:0]        orient_s1;
		logic [16:0]        unit_s1;
		logic signed [47:0] f_s2;
		logic signed [33:0] td_s2;
		logic signed [33:0] tp_s2;
		logic [31:0]        v_s3, v_s4, v_s5;
		logic signed [63:0] vdt_s4;
		logic [31:0]        p_s5;
		logic signed [63:0] prod_d;
		logic signed [63:0] prod_p;
		logic signed [63:0] vsum;
		logic signed [63:0] psum;
		logic [31:0]        p_out;
		logic [31:0]        v_out;

		always_comb begin
			prod_d = $signed({17'b0, kd_s1}) * $signed({{47{unit_s1[16]}}, unit_s1});
			prod_p = $signed({17'b0, kp_s1}) * $signed({{48{orient_s1[15]}}, orient_s1});
			vsum   = $signed({{16{f_s2[47]}}, f_s2}) + $signed({{30{td_s2[33]}}, td_s2})
				+ $signed({{30{tp_s2[33]}}, tp_s2});
			psum   = $signed({{32{pos_s4[31]}}, pos_s4})
				+ $signed({{16{vdt_s4[63]}}, vdt_s4[63:16]});
		end

		always_ff @(posedge clk) begin
			fdt_s1    <= $signed({{32{in_work.item.frc[a][31]}}, in_work.item.frc[a]})
				* $signed({33'b0, cfg.time_step});
			pos_s1    <= in_work.item.pos[a];
			orient_s1 <= in_work.item.orient[a];
			unit_s1   <= in_work.unit[a];

			f_s2   <= fdt_s1[63:16];
			td_s2  <= prod_d[63:30];
			tp_s2  <= prod_p[63:30];
			pos_s2 <= pos_s1;

			v_s3   <= sat32(vsum);
			pos_s3 <= pos_s2;

			vdt_s4 <= $signed({{32{v_s3[31]}}, v_s3}) * $signed({33'b0, cfg.time_step});
			v_s4   <= v_s3;
			pos_s4 <= pos_s3;

			p_s5 <= sat32(psum);
			v_s5 <= v_s4;

			new_pos[a] <= p_out;
			vel[a]     <= v_out;
		end

		if (PERIODIC_WRAP) begin : g_wrap
			logic signed [33:0] up_w, lo_w, span_w, p_w;
			always_comb begin
				up_w   = $signed({{2{cfg.upper[a][31]}}, cfg.upper[a]});
				lo_w   = $signed({{2{cfg.lower[a][31]}}, cfg.lower[a]});
				span_w = up_w - lo_w;
				p_w    = $signed({{2{p_s5[31]}}, p_s5});
				if (p_w > up_w) begin
					p_w = p_w - span_w;
				end
				if (p_w < lo_w) begin
					p_w = p_w + span_w;
				end
				p_out = sat32({{30{p_w[33]}}, p_w});
				v_out = v_s5;
			end
		end else begin : g_clamp
			always_comb begin
				p_out = p_s5;
				v_out = v_s5;
				if ($signed(p_out) > $signed(cfg.upper[a])) begin
					p_out = cfg.upper[a];
					v_out = 32'd0;
				end
				if ($signed(p_out) < $signed(cfg.lower[a])) begin
					p_out = cfg.lower[a];
					v_out = 32'd0;
				end
			end
		end
	end
endmodule
`default_nettype wire

[src/cell_position_integrate.sv]
// Channel   Direction  Handshake                Payload
// command   in         start, busy              pos_*, force_*, orient_*, random_*
// result    out        done (one-cycle strobe)  new_*, vel_*
// config    in         wr_en, wr_index          wr_data
//
// One transfer is taken per clock cycle; busy stays low in normal operation.
// A result reaches done after passing the 32-stage square root, the 16-stage
// divider, the queue and the 6-stage back end, in that order.
// Reset is asynchronous and active low; it empties every stage.
// The receiver cannot stall, so the back end drains the queue every cycle.
`default_nettype none
module cell_position_integrate #(
	parameter bit PERIODIC_WRAP = 1'b0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] force_x,
	input  logic [31:0] force_y,
	input  logic [31:0] force_z,
	input  logic [15:0] orient_x,
	input  logic [15:0] orient_y,
	input  logic [15:0] orient_z,
	input  logic [47:0] random_direction,
	input  logic [31:0] random_factors,
	output logic        done,
	output logic [31:0] new_x,
	output logic [31:0] new_y,
	output logic [31:0] new_z,
	output logic [31:0] vel_x,
	output logic [31:0] vel_y,
	output logic [31:0] vel_z,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);
	import cpi_pkg::*;

	cpi_cfg_t                 cfg_q;
	cpi_item_t                item;
	cpi_work_t                fr_work;
	cpi_work_t                q_work;
	logic                     fr_valid;
	logic                     q_valid;
	logic                     q_full;
	logic [NumAxes-1:0][31:0] new_pos;
	logic [NumAxes-1:0][31:0] vel;

	// Configuration registers must be written only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_ref <= ResetOneQ16;
			cfg_q.time_step <= ResetOneQ16;
			cfg_q.upper     <= {NumAxes{ResetUpper}};
			cfg_q.lower     <= {NumAxes{ResetLower}};
		end else if (wr_en) begin
			case (cpi_reg_t'(wr_index))
				REG_SPEED_REFERENCE: cfg_q.speed_ref <= wr_data[30:0];
				REG_TIME_STEP:       cfg_q.time_step <= wr_data[30:0];
				REG_X_UPPER:         cfg_q.upper[0]  <= wr_data;
				REG_X_LOWER:         cfg_q.lower[0]  <= wr_data;
				REG_Y_UPPER:         cfg_q.upper[1]  <= wr_data;
				REG_Y_LOWER:         cfg_q.lower[1]  <= wr_data;
				REG_Z_UPPER:         cfg_q.upper[2]  <= wr_data;
				REG_Z_LOWER:         cfg_q.lower[2]  <= wr_data;
				default: ;
			endcase
		end
	end

	// Gather the command fields into one item.
	always_comb begin
		item.pos         = {pos_z, pos_y, pos_x};
		item.frc         = {force_z, force_y, force_x};
		item.orient      = {orient_z, orient_y, orient_x};
		item.dir         = random_direction;
		item.dir_factor  = random_factors[15:0];
		item.prop_factor = random_factors[31:16];
	end

	// The queue never fills because the back end pops it every cycle, but
	// busy still reports a full queue so no transfer could be lost.
	assign busy = q_full;

	cpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_item  (item),
		.out_valid(fr_valid),
		.out_work (fr_work)
	);

	cpi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fr_valid),
		.push_data(fr_work),
		.pop      (q_valid),
		.not_empty(q_valid),
		.full     (q_full),
		.pop_data (q_work)
	);

	cpi_back #(
		.PERIODIC_WRAP(PERIODIC_WRAP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_work  (q_work),
		.cfg      (cfg_q),
		.out_valid(done),
		.new_pos  (new_pos),
		.vel      (vel)
	);

	assign new_x = new_pos[0];
	assign new_y = new_pos[1];
	assign new_z = new_pos[2];
	assign vel_x = vel[0];
	assign vel_y = vel[1];
	assign vel_z = vel[2];
endmodule
`default_nettype wire

[src/cpi_checker.sv]
`default_nettype none
module cpi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import cpi_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the queue is drained every cycle");

	a_quiet_in_reset: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done seen during reset");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##CpiLatency done)
		else $error("accepted transfer gave no result at the expected cycle");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, CpiLatency))
		else $error("result without a matching accepted transfer");
endmodule

bind cell_position_integrate cpi_checker u_cpi_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
`default_nettype wire
